### hw/rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg : shared types, constants and microcode for the voice mixer
// Holds the opcode set, the control word layout, the control program and the
// saturating mix add used by the datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int VOICES_DEF      = 4;
	localparam int CLIPS_DEF       = 8;
	localparam int MAX_SAMPLES_DEF = 4096;

	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF; // 32767
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000; // -32768

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SETLEN  = 2'd1,
		OP_TRIGGER = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	// Control program step addresses
	typedef enum logic [2:0] {
		S_LOAD    = 3'd0,
		S_SETLEN  = 3'd1,
		S_TRIG_RD = 3'd2,
		S_TRIG_WR = 3'd3,
		S_TICK    = 3'd4,
		S_MIX     = 3'd5,
		S_OUT     = 3'd6
	} step_t;

	// Sequencing condition of a control word
	typedef enum logic [1:0] {
		COND_NEXT     = 2'd0, // fall through to the next step
		COND_DIS      = 2'd1, // jump when the mixer is disabled
		COND_MORE     = 2'd2, // jump while voices remain
		COND_WAIT_OUT = 2'd3  // hold while the result register is occupied
	} cond_t;

	typedef struct packed {
		logic  mem_we;     // write one clip sample
		logic  len_we;     // write one clip length
		logic  len_rd;     // read a clip length for trigger
		logic  voice_load; // commit a trigger to a voice
		logic  acc_clr;    // clear accumulator and voice counter
		logic  mem_rd;     // fetch the sample of the next voice
		logic  mix;        // accumulate and advance the current voice
		logic  out_load;   // load the result register
		cond_t cond;
		step_t target;
		logic  fin;        // last step of the item
	} ucode_t;

	typedef struct packed {
		logic enable;
		logic last_voice;
		logic out_full;
	} seq_flags_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w        = '0;
		w.cond   = COND_NEXT;
		w.target = S_LOAD;
		unique case (s)
			S_LOAD: begin
				w.mem_we = 1'b1;
				w.fin    = 1'b1;
			end
			S_SETLEN: begin
				w.len_we = 1'b1;
				w.fin    = 1'b1;
			end
			S_TRIG_RD: begin
				w.len_rd = 1'b1;
			end
			S_TRIG_WR: begin
				w.voice_load = 1'b1;
				w.fin        = 1'b1;
			end
			S_TICK: begin
				w.acc_clr = 1'b1;
				w.mem_rd  = 1'b1;
				w.cond    = COND_DIS;
				w.target  = S_OUT;
			end
			S_MIX: begin
				w.mem_rd = 1'b1;
				w.mix    = 1'b1;
				w.cond   = COND_MORE;
				w.target = S_MIX;
			end
			S_OUT: begin
				w.out_load = 1'b1;
				w.cond     = COND_WAIT_OUT;
				w.fin      = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

	function automatic step_t entry_step(op_t op);
		step_t s;
		unique case (op)
			OP_LOAD:    s = S_LOAD;
			OP_SETLEN:  s = S_SETLEN;
			OP_TRIGGER: s = S_TRIG_RD;
			OP_TICK:    s = S_TICK;
			default:    s = S_LOAD;
		endcase
		return s;
	endfunction

	function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
		logic signed [15:0] b);
		logic signed [16:0] s;
		logic signed [15:0] r;
		s = {a[15], a} + {b[15], b};
		if (s[16] != s[15]) begin
			r = s[16] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/sample_voice_mixer_core.sv
// ----------------------------------------------------------------------------
// sample_voice_mixer_core : sample playback voice mixer
// Plays stored PCM clips on a set of voices and mixes one saturated 16-bit
// frame per tick. A small control program sequences a plain datapath.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | opcode, sound, address, sample_value,
//          |                      | clip_length
//  out     | out_valid / out_stall| mixed_sample, any_active
//  cfg     | cfg_we               | cfg_wdata (enable)
//
//  Steps: load runs S_LOAD and set length S_SETLEN, trigger S_TRIG_RD then
//  S_TRIG_WR; an enabled tick runs S_TICK, S_MIX once per voice and S_OUT,
//  a disabled tick S_TICK and S_OUT. A new item is taken the cycle after
//  the last step, none while one runs. The tick length is set by the
//  single read port of the clip memory, one voice per cycle.
//  Reset: no clearing pass. Clip samples are undefined until loaded; clip
//  lengths read as zero through one valid bit per clip.
//  Stalls: a result waits in the output register while the next items run;
//  only the final step of a tick holds while an older result is untaken.
//
module sample_voice_mixer_core #(
	parameter int VOICES           = svm_pkg::VOICES_DEF,
	parameter int CLIPS            = svm_pkg::CLIPS_DEF,
	parameter int MAX_CLIP_SAMPLES = svm_pkg::MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [2:0]         sound,
	input  logic [11:0]        address,
	input  logic signed [15:0] sample_value,
	input  logic [12:0]        clip_length,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] mixed_sample,
	output logic               any_active,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	import svm_pkg::*;

	localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CLIP_W    = (CLIPS > 1) ? $clog2(CLIPS) : 1;
	localparam int POS_W     = $clog2(MAX_CLIP_SAMPLES);
	localparam int LEN_W     = $clog2(MAX_CLIP_SAMPLES + 1);
	localparam int LEN_DEPTH = 2 ** CLIP_W;
	localparam int MEM_DEPTH = 2 ** (CLIP_W + POS_W);

	// ---------------------------------------------------------------- control
	logic       in_xfer, out_xfer;
	logic       busy;
	ucode_t     ctrl;
	seq_flags_t flags;
	logic       enable_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = busy;

	svm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.opcode (op_t'(opcode)),
		.flags  (flags),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------- captured item
	logic [2:0]         sound_q;
	logic [11:0]        address_q;
	logic signed [15:0] sample_q;
	logic [12:0]        clip_length_q;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sound_q       <= sound;
			address_q     <= address;
			sample_q      <= sample_value;
			clip_length_q <= clip_length;
		end
	end

	logic              snd_ok, addr_ok;
	logic [CLIP_W-1:0] clip_idx;

	assign snd_ok   = 32'(sound_q) < 32'(CLIPS);
	assign addr_ok  = 32'(address_q) < 32'(MAX_CLIP_SAMPLES);
	assign clip_idx = CLIP_W'(sound_q);

	// ------------------------------------------------------------ clip lengths
	logic [LEN_W-1:0]     len_wdata, len_rdata;
	logic [LEN_DEPTH-1:0] len_vld_q;
	logic                 len_ok_q;

	// clamp an oversize length to the clip capacity
	assign len_wdata = (32'(clip_length_q) > 32'(MAX_CLIP_SAMPLES)) ?
		LEN_W'(MAX_CLIP_SAMPLES) : LEN_W'(clip_length_q);

	svm_ram #(
		.WIDTH (LEN_W),
		.DEPTH (LEN_DEPTH)
	) u_len_ram (
		.clk   (clk),
		.we    (ctrl.len_we && snd_ok),
		.waddr (clip_idx),
		.wdata (len_wdata),
		.raddr (clip_idx),
		.rdata (len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (ctrl.len_we && snd_ok) begin
			len_vld_q[clip_idx] <= 1'b1;
		end
	end

	// sample the valid bit alongside the registered length read
	always_ff @(posedge clk) begin
		if (ctrl.len_rd) begin
			len_ok_q <= len_vld_q[clip_idx];
		end
	end

	// ------------------------------------------------------------ voice state
	logic [VOICES-1:0] live_q;
	logic [CLIP_W-1:0] vclip_q [VOICES];
	logic [LEN_W-1:0]  vpos_q  [VOICES];
	logic [LEN_W-1:0]  vlen_q  [VOICES];
	logic [VW-1:0]     steal_q;
	logic [VW-1:0]     vc_q;
	logic              vc_last;

	assign vc_last = (vc_q == VW'(VOICES - 1));

	// lowest free voice, else the steal pointer
	logic          free_found;
	logic [VW-1:0] free_idx, slot;
	logic          do_trig;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = VW'(i);
			end
		end
	end

	assign slot    = free_found ? free_idx : steal_q;
	assign do_trig = ctrl.voice_load && enable_q && snd_ok;

	// ------------------------------------------------------------ clip store
	logic [VW-1:0]              rd_v;
	logic [CLIP_W+POS_W-1:0]    mem_raddr, mem_waddr;
	logic [15:0]                mem_rdata;

	// fetch one voice ahead of the one being mixed
	assign rd_v      = (ctrl.acc_clr || vc_last) ? '0 : vc_q + VW'(1);
	assign mem_raddr = {vclip_q[rd_v], POS_W'(vpos_q[rd_v])};
	assign mem_waddr = {clip_idx, POS_W'(address_q)};

	svm_ram #(
		.WIDTH (16),
		.DEPTH (MEM_DEPTH)
	) u_clip_ram (
		.clk   (clk),
		.we    (ctrl.mem_we && snd_ok && addr_ok),
		.waddr (mem_waddr),
		.wdata (sample_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ------------------------------------------------------------ mix step
	logic signed [15:0] acc_q;
	logic               play;
	logic [LEN_W-1:0]   pos_new;

	assign play    = live_q[vc_q] && (vpos_q[vc_q] < vlen_q[vc_q]);
	assign pos_new = play ? vpos_q[vc_q] + LEN_W'(1) : vpos_q[vc_q];

	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.mix && play) begin
			acc_q <= sat_add(acc_q, $signed(mem_rdata));
		end
	end

	always_ff @(posedge clk) begin
		if (do_trig) begin
			vclip_q[slot] <= clip_idx;
			vlen_q[slot]  <= len_ok_q ? len_rdata : '0;
			vpos_q[slot]  <= '0;
		end else if (ctrl.mix) begin
			vpos_q[vc_q] <= pos_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			steal_q <= '0;
			vc_q    <= '0;
		end else begin
			if (ctrl.acc_clr) begin
				vc_q <= '0;
			end else if (ctrl.mix) begin
				vc_q <= vc_last ? '0 : vc_q + VW'(1);
			end
			if (do_trig) begin
				live_q[slot] <= 1'b1;
				// advance the pointer on a steal only
				if (!free_found) begin
					steal_q <= (steal_q == VW'(VOICES - 1)) ? '0 : steal_q + VW'(1);
				end
			end else if (ctrl.mix && live_q[vc_q] && (pos_new >= vlen_q[vc_q])) begin
				// retire a voice that reached its length
				live_q[vc_q] <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------ result
	logic               out_valid_q;
	logic signed [15:0] mixed_q;
	logic               any_q;

	assign flags.enable     = enable_q;
	assign flags.last_voice = vc_last;
	assign flags.out_full   = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			mixed_q <= acc_q;
			any_q   <= |live_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign any_active   = any_q;

endmodule

### hw/rtl/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram : generic single-write, single-read RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module svm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/svm_seq.sv
// ----------------------------------------------------------------------------
// svm_seq : microcode sequencer of the voice mixer
// Step counter over the control program; dispatches on the opcode of an
// accepted item and emits one control word per cycle.
// ----------------------------------------------------------------------------
module svm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  svm_pkg::op_t       opcode,
	input  svm_pkg::seq_flags_t flags,
	output logic               busy,
	output svm_pkg::ucode_t    ctrl
);
	import svm_pkg::*;

	logic   busy_q, busy_d;
	step_t  upc_q, upc_d;
	ucode_t word;
	logic   hold;
	step_t  upc_inc;

	assign word    = ucode_rom(upc_q);
	assign hold    = (word.cond == COND_WAIT_OUT) && flags.out_full;
	assign upc_inc = step_t'(3'(upc_q) + 3'd1);
	assign busy    = busy_q;

	// next step
	always_comb begin
		busy_d = busy_q;
		upc_d  = upc_q;
		if (!busy_q) begin
			if (start) begin
				busy_d = 1'b1;
				upc_d  = entry_step(opcode);
			end
		end else begin
			unique case (word.cond)
				COND_NEXT:     upc_d = upc_inc;
				COND_DIS:      upc_d = flags.enable ? upc_inc : word.target;
				COND_MORE:     upc_d = flags.last_voice ? upc_inc : word.target;
				COND_WAIT_OUT: upc_d = hold ? upc_q : upc_inc;
				default:       upc_d = upc_inc;
			endcase
			if (word.fin && !hold) begin
				busy_d = 1'b0;
			end
		end
	end

	// control word out
	always_comb begin
		ctrl = '0;
		if (busy_q) begin
			ctrl = word;
			if (hold) begin
				ctrl.out_load = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= S_LOAD;
		end else begin
			busy_q <= busy_d;
			upc_q  <= upc_d;
		end
	end

endmodule

### hw/rtl/svm_props.sv
// ----------------------------------------------------------------------------
// svm_props : port-level checks for the voice mixer
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module svm_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         opcode,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] mixed_sample,
	input logic               any_active
);
	import svm_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// a transfer in always starts the sequencer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input transfer did not start the sequencer");

	// load and set length never produce a result
	a_no_result_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (opcode == OP_LOAD || opcode == OP_SETLEN)
		|=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result raised after a load or set length");

	// a new result only appears at the end of a running tick
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall
		|=> out_valid && $stable(mixed_sample) && $stable(any_active))
		else $error("stalled result changed");

endmodule

bind sample_voice_mixer_core svm_props u_props (.*);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb : self-checking bench for sample_voice_mixer_core
// Drives directed and random load / set length / trigger / tick items through
// the valid-stall input channel. A behavioral model of the voices predicts
// each frame but the hand-typed ones, and every frame transfer is checked.
// ----------------------------------------------------------------------------
module tb;

	import svm_pkg::*;

	localparam int NV      = VOICES_DEF;
	localparam int NCLIP   = CLIPS_DEF;
	localparam int NSAMP   = MAX_SAMPLES_DEF;
	localparam int SETTLE  = 16;          // cycles to let a trigger or load finish
	localparam int SEG_LEN = 100;         // random items per enable setting
	localparam int SEGS    = 5;           // enable settings per idling phase
	localparam longint RUN_LIMIT = 64'd5_000_000;

	// One input item, one field per port.
	typedef struct {
		op_t                op;
		logic [2:0]         snd;
		logic [11:0]        addr;
		logic signed [15:0] smp;
		logic [12:0]        len;
	} mix_op_t;

	// One output frame.
	typedef struct {
		logic signed [15:0] mix;
		logic               act;
	} frame_t;

	// Directed row: optional enable write ahead of the item, optional
	// hand-typed frame for ticks whose answer is obvious.
	typedef struct {
		bit                 en_set;
		bit                 en_val;
		mix_op_t            item;
		bit                 typed;
		logic signed [15:0] t_mix;
		logic               t_act;
	} dir_row_t;

	// ------------------------------------------------------------------------
	// DUT ports; the inputs are known from time zero
	// ------------------------------------------------------------------------
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode       = '0;
	logic [2:0]         sound        = '0;
	logic [11:0]        address      = '0;
	logic signed [15:0] sample_value = '0;
	logic [12:0]        clip_length  = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic signed [15:0] mixed_sample;
	logic               any_active;
	logic               cfg_we       = 1'b0;
	logic               cfg_wdata    = 1'b0;

	sample_voice_mixer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sound        (sound),
		.address      (address),
		.sample_value (sample_value),
		.clip_length  (clip_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mixed_sample (mixed_sample),
		.any_active   (any_active),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Voice model state: clip memory with a written mask, clip lengths,
	// per-voice live / clip / position / length, steal pointer, enable.
	// ------------------------------------------------------------------------
	logic signed [15:0] clip_mem [NCLIP][NSAMP];
	bit                 written  [NCLIP][NSAMP];
	logic [12:0]        clip_len [NCLIP];
	logic               v_live   [NV];
	logic [2:0]         v_clip   [NV];
	logic [12:0]        v_pos    [NV];
	logic [12:0]        v_len    [NV];
	int                 steal_ptr;
	logic               mix_en;

	frame_t   frame_q [$];    // frames owed by the DUT, oldest first
	dir_row_t dir_tab [$];
	int       mismatches   = 0;
	int       in_idle_pct  = 0;
	int       out_stall_pct = 0;
	frame_t   want_f;

	// Advance the model by one accepted item; report the frame a tick yields.
	task automatic mix_model(input mix_op_t it, output bit has_frame, output frame_t f);
		int acc;
		int slot;
		has_frame = 1'b0;
		f.mix     = '0;
		f.act     = 1'b0;
		case (it.op)
			OP_LOAD: begin
				if (it.snd < NCLIP && it.addr < NSAMP) begin
					clip_mem[it.snd][it.addr] = it.smp;
					written[it.snd][it.addr]  = 1'b1;
				end
			end
			OP_SETLEN: begin
				// clamp lengths beyond the clip capacity
				if (it.snd < NCLIP)
					clip_len[it.snd] = (it.len > NSAMP) ? 13'(NSAMP) : it.len;
			end
			OP_TRIGGER: begin
				if (mix_en && it.snd < NCLIP) begin
					slot = NV;
					for (int i = 0; i < NV; i++)
						if (!v_live[i] && slot == NV) slot = i;
					// all busy: steal at the pointer and advance it
					if (slot == NV) begin
						slot      = steal_ptr;
						steal_ptr = (steal_ptr + 1) % NV;
					end
					v_clip[slot] = it.snd;
					v_len[slot]  = clip_len[it.snd];
					v_pos[slot]  = '0;
					v_live[slot] = 1'b1;
				end
			end
			OP_TICK: begin
				acc = 0;
				if (mix_en) begin
					for (int v = 0; v < NV; v++) begin
						if (v_live[v]) begin
							if (v_pos[v] < v_len[v]) begin
								acc = acc + int'(clip_mem[v_clip[v]][v_pos[v][11:0]]);
								if (acc > int'(SAMPLE_MAX)) acc = int'(SAMPLE_MAX);
								if (acc < int'(SAMPLE_MIN)) acc = int'(SAMPLE_MIN);
								v_pos[v] = v_pos[v] + 13'd1;
							end
							// zero-length or finished voice retires here
							if (v_pos[v] >= v_len[v]) v_live[v] = 1'b0;
						end
					end
				end
				f.mix = acc[15:0];
				for (int v = 0; v < NV; v++)
					if (v_live[v]) f.act = 1'b1;
				has_frame = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Present one item and hold it until the transfer; enter and leave at
	// a falling edge so valid gets exactly one assignment per step.
	task automatic send_item(input mix_op_t it, input bit typed,
		input logic signed [15:0] t_mix, input logic t_act);
		bit     hf;
		frame_t f;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= it.op;
		sound        <= it.snd;
		address      <= it.addr;
		sample_value <= it.smp;
		clip_length  <= it.len;
		do @(posedge clk); while (in_stall);
		mix_model(it, hf, f);
		if (hf) begin
			if (typed) begin
				f.mix = t_mix;
				f.act = t_act;
			end
			frame_q.push_back(f);
		end
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		int r;
		r = $urandom_range(99);
		if (r < 8) return SAMPLE_MAX;
		if (r < 16) return SAMPLE_MIN;
		return 16'($urandom);
	endfunction

	// Issue an item; ahead of a tick, load any sample a live voice is about
	// to play that was never written, so no undefined memory is read.
	task automatic issue(input mix_op_t it, input bit typed,
		input logic signed [15:0] t_mix, input logic t_act);
		mix_op_t ld;
		if (it.op == OP_TICK && mix_en) begin
			for (int v = 0; v < NV; v++) begin
				if (v_live[v] && v_pos[v] < v_len[v] && !written[v_clip[v]][v_pos[v][11:0]]) begin
					ld.op   = OP_LOAD;
					ld.snd  = v_clip[v];
					ld.addr = v_pos[v][11:0];
					ld.smp  = rand_sample();
					ld.len  = 13'($urandom);
					send_item(ld, 1'b0, '0, 1'b0);
				end
			end
		end
		send_item(it, typed, t_mix, t_act);
	endtask

	// Drop valid, wait for every owed frame, then let in-flight loads and
	// triggers finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write the enable register; only called with the block idle.
	task automatic write_enable(input logic val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		mix_en = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic mix_op_t rand_item();
		mix_op_t it;
		int      r;
		int      q;
		it.snd  = 3'($urandom);
		it.addr = 12'($urandom);
		it.smp  = rand_sample();
		it.len  = 13'($urandom);
		r = $urandom_range(99);
		if (r < 25) begin
			it.op = OP_LOAD;
			// mostly the head of a clip, where short clips play
			if ($urandom_range(99) < 75) it.addr = 12'($urandom_range(31));
		end else if (r < 37) begin
			it.op = OP_SETLEN;
			q = $urandom_range(99);
			if (q < 84) it.len = 13'($urandom_range(24));
			else if (q < 96) it.len = 13'($urandom);
			else if (q < 97) it.len = 13'd0;
			else if (q < 98) it.len = 13'(NSAMP);
			else it.len = 13'h1FFF;
		end else if (r < 57) begin
			it.op = OP_TRIGGER;
		end else begin
			it.op = OP_TICK;
		end
		return it;
	endfunction

	function automatic dir_row_t drow(bit es, bit ev, op_t op, int snd, int addr,
		int smp, int len, bit typed, int tm, bit ta);
		dir_row_t d;
		d.en_set    = es;
		d.en_val    = ev;
		d.item.op   = op;
		d.item.snd  = snd[2:0];
		d.item.addr = addr[11:0];
		d.item.smp  = smp[15:0];
		d.item.len  = len[12:0];
		d.typed     = typed;
		d.t_mix     = tm[15:0];
		d.t_act     = ta;
		return d;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: stall at random, check every frame transfer in order
	// ------------------------------------------------------------------------
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < out_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frame_q.size() == 0) begin
				$error("frame with nothing owed: mixed_sample %0d any_active %0b",
					mixed_sample, any_active);
				mismatches++;
			end else begin
				want_f = frame_q.pop_front();
				if (mixed_sample !== want_f.mix) begin
					$error("mixed_sample: expected %0d, got %0d", want_f.mix, mixed_sample);
					mismatches++;
				end
				if (any_active !== want_f.act) begin
					$error("any_active: expected %0b, got %0b", want_f.act, any_active);
					mismatches++;
				end
			end
		end
	end

	// Hard stop on a hang.
	initial begin
		#(RUN_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		for (int c = 0; c < NCLIP; c++) begin
			clip_len[c] = '0;
			for (int a = 0; a < NSAMP; a++) begin
				clip_mem[c][a] = '0;
				written[c][a]  = 1'b0;
			end
		end
		for (int v = 0; v < NV; v++) begin
			v_live[v] = 1'b0;
			v_clip[v] = '0;
			v_pos[v]  = '0;
			v_len[v]  = '0;
		end
		steal_ptr = 0;
		mix_en    = 1'b0;

		// Directed rows. Disabled first: ticks are silent, triggers dropped.
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 1, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_LOAD,    0, 0, 32767, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_SETLEN,  0, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 1, 0, 0));
		// Enabled: two copies of a full-scale one-sample clip saturate high.
		dir_tab.push_back(drow(1, 1, OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 1, 32767, 0));
		// Two copies of a negative full-scale sample saturate low.
		dir_tab.push_back(drow(0, 0, OP_LOAD,    7, 0, -32768, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_SETLEN,  7, 0, 0, 2, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 7, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 7, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 1, -32768, 1));
		// Load into a clip that is playing: the voices see it at once.
		dir_tab.push_back(drow(0, 0, OP_LOAD,    7, 1, 1, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 1, 2, 0));
		dir_tab.push_back(drow(0, 0, OP_LOAD,    7, 4095, 16'h1234, 0, 0, 0, 0));
		// Oversized length clamps; zero-length voice retires in silence.
		dir_tab.push_back(drow(0, 0, OP_SETLEN,  1, 0, 0, 8191, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_SETLEN,  2, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 2, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 1, 0, 0));
		// Fill every voice, then steal twice.
		for (int i = 0; i < NV; i++)
			dir_tab.push_back(drow(0, 0, OP_TRIGGER, 1, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 7, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TRIGGER, 7, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(drow(0, 0, OP_TICK,    0, 0, 0, 0, 0, 0, 0));
		// Disabled with voices live: silence, but still active.
		dir_tab.push_back(drow(1, 0, OP_TICK,    0, 0, 0, 0, 1, 0, 1));

		// Hold reset, then release it once.
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		in_idle_pct   = 16;
		out_stall_pct = 65;
		write_enable(1'b0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].en_set) write_enable(dir_tab[i].en_val);
			issue(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].t_mix, dir_tab[i].t_act);
		end

		// Random part: three idling phases, each walking several enable
		// settings; one segment per phase runs disabled.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					in_idle_pct   = 16;
					out_stall_pct = 65;
				end
				1: begin
					in_idle_pct   = 65;
					out_stall_pct = 16;
				end
				default: begin
					in_idle_pct   = 0;
					out_stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGS; seg++) begin
				write_enable((seg == 2) ? 1'b0 : 1'b1);
				repeat (SEG_LEN) issue(rand_item(), 1'b0, '0, 1'b0);
			end
		end

		// Drain and report.
		wait_idle();
		if (mismatches == 0 && frame_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
